@@ hdl/sdtq_pkg.sv @@
// sdtq_pkg: shared types and constants for the sorted deadline timer queue
// no dependencies
`default_nettype none
package sdtq_pkg;

    localparam int DL_W = 48;
    localparam int MS_W = 31;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEL   = 2'd1,
        CMD_RST   = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] now_us;
        logic [31:0] timeout_ms;
        logic [7:0]  timer_kind;
        logic [15:0] target_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_id;
        logic [30:0] ms_left;
        logic [7:0]  front_kind;
    } t_out_item;

endpackage
`default_nettype wire

@@ hdl/sdtq_div1000.sv @@
// sdtq_div1000: divide of a 48-bit value by 1000 through a reciprocal multiply, saturated to 31 bits
// no dependencies
`default_nettype none
module sdtq_div1000 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_num,
    output logic             o_done,
    output logic [30:0]      o_ms
);
    // q = floor((x >> 3) * M / 2^45) with M = ceil(2^45 / 125), exact for x below 2^41
    // larger x, and quotients of 2^31 or more, saturate
    localparam logic [19:0] M_HI = 20'h41893;
    localparam logic [19:0] M_LO = 20'h74BC7;

    logic [39:0] r_num;
    logic        r_big;
    logic [79:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic [19:0] w_pa;
    logic [19:0] w_pm;
    logic [39:0] w_pp;
    logic [79:0] w_add;

    // one 20x20 partial product per cycle, four in all
    assign w_pa = r_step[1] ? r_num[39:20] : r_num[19:0];
    assign w_pm = r_step[0] ? M_HI : M_LO;
    assign w_pp = 40'(w_pa) * 40'(w_pm);

    always_comb begin
        case (r_step)
            2'd0:    w_add = {40'd0, w_pp};
            2'd3:    w_add = {w_pp, 40'd0};
            default: w_add = {20'd0, w_pp, 20'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_num  <= {2'b00, i_num[40:3]};
                r_big  <= |i_num[47:41];
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc  <= r_acc + w_add;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) r_busy <= 1'b0;
            end
        end
    end

    assign o_ms = (r_big || r_acc[76]) ? {31{1'b1}} : r_acc[75:45];
endmodule
`default_nettype wire

@@ hdl/sorted_deadline_timer_queue_unit.sv @@
// sorted timer queue: entries in one memory, sorted by deadline, slot 0 is the front
// query uses a four-step reciprocal multiply by 1/1000; empty or full ends without a scan
// one item at a time; the next item is taken once the result sits in the output register
// synchronous active-low reset clears count and sets the id counter to 1; memory needs no clearing
// depends on sdtq_pkg, sdtq_div1000
`default_nettype none
module sorted_deadline_timer_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire sdtq_pkg::t_in_item i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output sdtq_pkg::t_out_item     o_item
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 48 + ID_BITS + 8;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FIND  = 8'b00000010,
        S_FCHK  = 8'b00000100,
        S_REMV  = 8'b00001000,
        S_INSR  = 8'b00010000,
        S_ICHK  = 8'b00100000,
        S_DIV   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    // memory: {deadline, id, kind}
    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    t_state            r_st;
    sdtq_pkg::t_in_item r_in;
    logic [CW-1:0]     r_cnt;
    logic [ID_BITS-1:0] r_nid;
    logic [CW-1:0]     r_pos;     // scan index
    logic              r_rdpend;  // read issued last cycle
    logic [47:0]       r_dl;
    logic [7:0]        r_kind;
    logic              r_ins;     // new entry placed, carried entries being shifted down
    logic [EW-1:0]     r_carry;   // entry being shifted down the queue
    sdtq_pkg::t_out_item r_out;
    sdtq_pkg::t_out_item r_obuf;  // result item on the output
    logic              r_ov;
    logic              r_dstart;
    logic              w_ddone;
    logic [30:0]       w_dms;

    logic [48:0] w_sum;
    logic [47:0] w_dlsat;
    logic [47:0] w_rd_dl;
    logic [ID_BITS-1:0] w_rd_id;
    logic [ID_BITS-1:0] w_take;
    logic [ID_BITS-1:0] w_next;

    assign w_rd_dl = r_rd[EW-1 -: 48];
    assign w_rd_id = r_rd[8 +: ID_BITS];
    assign w_sum   = {1'b0, r_in.now_us} + 49'(r_in.timeout_ms) * 49'd1000;
    assign w_dlsat = w_sum[48] ? {48{1'b1}} : w_sum[47:0];
    assign w_take  = (r_nid == '0) ? ID_BITS'(1) : r_nid;
    assign w_next  = (r_nid == '0) ? ID_BITS'(2) : ID_BITS'(r_nid + ID_BITS'(1));

    sdtq_div1000 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   ((w_rd_dl > r_in.now_us) ? 48'(w_rd_dl - r_in.now_us) : 48'd0),
        .o_done  (w_ddone),
        .o_ms    (w_dms)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_item  = r_obuf;

    // read address follows scan position
    always_comb begin
        w_raddr = r_pos[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_pos[AW-1:0];
        w_wdata = r_carry;
        case (r_st)
            S_REMV: begin
                // write entry pos into pos-1, on data arrival
                if (r_rdpend) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_pos - CW'(1));
                    w_wdata = r_rd;
                end
            end
            S_ICHK: begin
                if (r_rdpend) begin
                    w_we = 1'b1;
                    if (r_pos == r_cnt || w_rd_dl > r_dl || r_ins) begin
                        w_wdata = r_ins ? r_carry : {r_dl, w_take, r_kind};
                    end else begin
                        w_wdata = r_rd;
                    end
                    w_waddr = r_pos[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_cnt    <= '0;
            r_nid    <= ID_BITS'(1);
            r_ov     <= 1'b0;
            r_rdpend <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= (r_st == S_FIND) && (r_in.command == sdtq_pkg::CMD_QUERY) &&
                        (r_cnt != '0);
            if (r_st == S_OUT && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in     <= i_item;
                        r_pos    <= '0;
                        r_rdpend <= 1'b0;
                        r_out    <= '0;
                        r_ins    <= 1'b0;
                        r_st     <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_rdpend <= 1'b1;
                    case (sdtq_pkg::t_cmd'(r_in.command))
                        sdtq_pkg::CMD_ADD: begin
                            if (r_cnt == CW'(QUEUE_DEPTH)) begin
                                r_out.status <= sdtq_pkg::ST_FULL;
                                r_st <= S_OUT;
                            end else begin
                                r_dl   <= w_dlsat;
                                r_kind <= r_in.timer_kind;
                                r_st   <= S_INSR;
                            end
                        end
                        sdtq_pkg::CMD_QUERY: begin
                            if (r_cnt == '0) begin
                                r_out.status <= sdtq_pkg::ST_EMPTY;
                                r_st <= S_OUT;
                            end else begin
                                r_st <= S_DIV;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                r_out.status <= sdtq_pkg::ST_EMPTY;
                                r_st <= S_OUT;
                            end else begin
                                r_st <= S_FCHK;
                            end
                        end
                    endcase
                end
                S_FCHK: begin
                    // r_rd holds entry r_pos
                    if (r_pos == r_cnt) begin
                        r_out.status <= sdtq_pkg::ST_NOT_FOUND;
                        r_st <= S_OUT;
                    end else if (32'(w_rd_id) == 32'(r_in.target_id)) begin
                        r_kind   <= r_rd[7:0];
                        r_pos    <= r_pos + CW'(1);
                        r_rdpend <= 1'b0;
                        r_st     <= S_REMV;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                        r_st  <= S_FIND;
                    end
                end
                S_REMV: begin
                    if (r_pos >= r_cnt) begin
                        r_cnt <= r_cnt - CW'(1);
                        r_rdpend <= 1'b0;
                        if (r_in.command == sdtq_pkg::CMD_RST) begin
                            r_dl  <= w_dlsat;
                            r_pos <= '0;
                            r_st  <= S_INSR;
                        end else begin
                            r_st <= S_OUT;
                        end
                    end else if (r_rdpend) begin
                        r_rdpend <= 1'b0;
                        r_pos    <= r_pos + CW'(1);
                    end else begin
                        r_rdpend <= 1'b1;
                    end
                end
                S_INSR: begin
                    r_rdpend <= 1'b1;
                    r_st     <= S_ICHK;
                end
                S_ICHK: begin
                    r_rdpend <= 1'b0;
                    if (r_pos == r_cnt) begin
                        // last slot written this cycle
                        if (!r_ins) begin
                            r_out.new_id <= 16'(w_take);
                            r_nid        <= w_next;
                        end
                        r_cnt <= r_cnt + CW'(1);
                        r_st  <= S_OUT;
                    end else begin
                        if (!r_ins && w_rd_dl > r_dl) begin
                            r_ins        <= 1'b1;
                            r_out.new_id <= 16'(w_take);
                            r_nid        <= w_next;
                        end
                        if (r_ins || w_rd_dl > r_dl) r_carry <= r_rd;
                        r_pos <= r_pos + CW'(1);
                        r_st  <= S_INSR;
                    end
                end
                S_DIV: begin
                    if (r_dstart == 1'b0 && w_ddone) begin
                        r_out.ms_left    <= w_dms;
                        r_out.front_kind <= r_rd[7:0];
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_obuf <= r_out;
                        r_st   <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/sdtq_checker.sv @@
// sdtq_checker: port-level checks for the timer queue top level
// depends on sdtq_pkg; bound to sorted_deadline_timer_queue_unit
`default_nettype none
module sdtq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire sdtq_pkg::t_out_item o_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output item changed while stalled");
    a_query_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.new_id != 16'd0 |-> o_item.ms_left == 31'd0 &&
        o_item.status == sdtq_pkg::ST_OK)
        else $error("id and time both reported");
    a_err_noid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != sdtq_pkg::ST_OK |-> o_item.new_id == 16'd0)
        else $error("failed command gave an id");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken at once");
endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
);
`default_nettype wire
